/* hw/rtl/bocl_pkg.sv */
package bocl_pkg;

   // configuration register indexes
   localparam logic [7:0] CSR_DEADZONE_WIDTH   = 8'd0;
   localparam logic [7:0] CSR_SWITCH_PERIOD_US = 8'd1;
   localparam logic [7:0] CSR_VALVE_BIAS       = 8'd2;
   localparam logic [7:0] CSR_VALVE_GAIN_P     = 8'd3;
   localparam logic [7:0] CSR_VALVE_GAIN_D     = 8'd4;
   localparam logic [7:0] CSR_MOTOR_BIAS       = 8'd5;
   localparam logic [7:0] CSR_MOTOR_GAIN_P     = 8'd6;
   localparam logic [7:0] CSR_MOTOR_GAIN_D     = 8'd7;

   // register reset values
   localparam logic [22:0] DEADZONE_WIDTH_RST   = 23'd6554;
   localparam logic [31:0] SWITCH_PERIOD_US_RST = 32'd250000;
   localparam logic [16:0] VALVE_BIAS_RST       = 17'd53740;
   localparam logic [23:0] VALVE_GAIN_P_RST     = 24'd4588;
   localparam logic [23:0] VALVE_GAIN_D_RST     = 24'd1638;
   localparam logic [16:0] MOTOR_BIAS_RST       = 17'd6554;
   localparam logic [23:0] MOTOR_GAIN_P_RST     = 24'd65536;
   localparam logic [23:0] MOTOR_GAIN_D_RST     = 24'd13107;

   // minimum valve command, Q16 fraction of full
   localparam int unsigned VALVE_FLOOR = 45875;
   // lowest valve duty the floor allows
   localparam logic [7:0] VALVE_FLOOR_DUTY = 8'((VALVE_FLOOR * 255) / 65536);

   localparam logic [7:0] DUTY_FULL = 8'd255;
   localparam logic [7:0] DUTY_OFF  = 8'd0;

   typedef struct packed {
      logic [31:0]        now_us;
      logic signed [23:0] setpoint;
      logic signed [23:0] distance;
      logic signed [23:0] velocity;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] valve_duty;
      logic [7:0] pump_duty;
      logic       onoff_valve;
      logic       closing;
   } rsp_payload_type;

endpackage

/* hw/rtl/brake_open_close_control_law_core.sv */
// channel | ports                              | direction | beat
// req     | req_valid, req_ready, req_data     | in        | one control tick
// rsp     | rsp_valid, rsp_ready, rsp_data     | out       | one duty set per tick
// csr     | csr_valid, csr_ready, csr_index/data | in      | one register write
//
// three register stages: input, products, result; a tick passes through them in that
// order, and one tick is taken every cycle while the result side is not stalled.
// the mode flip and gain select share the cycle with the two multipliers.
// reset is synchronous: empties the pipe, sets closing mode, loads defaults.
// a stalled result holds the whole pipe; empty stages still take new beats.
module brake_open_close_control_law_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bocl_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bocl_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_index,
   input  logic [31:0]               csr_data
);
   import bocl_pkg::*;

   localparam logic signed [51:0] FLOOR_Q32 = 52'(VALVE_FLOOR) <<< 16;
   localparam logic [32:0]        ONE_Q32   = 33'h1_0000_0000;

   typedef struct packed {
      logic               closing;
      logic               err_neg;
      logic               err_pos;
      logic [16:0]        bias;
      logic signed [49:0] p_err;
      logic signed [48:0] p_vel;
   } prod_stage_type;

   // configuration registers
   logic [22:0] deadzone_ff;
   logic [31:0] period_ff;
   logic [16:0] valve_bias_ff;
   logic [23:0] valve_kp_ff;
   logic [23:0] valve_kd_ff;
   logic [16:0] motor_bias_ff;
   logic [23:0] motor_kp_ff;
   logic [23:0] motor_kd_ff;

   // control state
   logic        closing_ff;
   logic        closing_in;
   logic [31:0] last_flip_ff;
   logic [31:0] last_flip_in;

   // pipeline
   logic            in_vld_ff;
   req_payload_type in_ff;
   logic            pr_vld_ff;
   prod_stage_type  pr_ff;
   prod_stage_type  pr_in;
   logic            out_vld_ff;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;

   logic en_out;
   logic en_pr;
   logic en_in;

   // stage one signals
   logic signed [24:0] err;
   logic signed [24:0] dz_pos;
   logic signed [24:0] dz_neg;
   logic [31:0]        elapsed;
   logic               may_flip;
   logic               open_flip;
   logic               close_flip;
   logic [23:0]        kp_sel;
   logic [23:0]        kd_sel;

   // stage two signals
   logic signed [51:0] cmd;
   logic signed [51:0] cmd_floored;
   logic [32:0]        cmd_clamped;
   logic [39:0]        scaled;
   logic [7:0]         duty;

   // stall chain: a stage moves when the next one is free or moving
   assign en_out    = !out_vld_ff || rsp_ready;
   assign en_pr     = !pr_vld_ff || en_out;
   assign en_in     = !in_vld_ff || en_pr;
   assign req_ready = en_in;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;
   assign csr_ready = 1'b1;

   // mode flip decision
   assign err      = $signed({in_ff.setpoint[23], in_ff.setpoint})
                   - $signed({in_ff.distance[23], in_ff.distance});
   assign dz_pos   = $signed({2'b00, deadzone_ff});
   assign dz_neg   = -dz_pos;
   assign elapsed  = in_ff.now_us - last_flip_ff;
   assign may_flip = elapsed > period_ff;
   assign open_flip  = may_flip && (err >= dz_pos);
   // an opening flip masks the closing test, so no second flip
   assign close_flip = may_flip && !open_flip && (err <= dz_neg);

   always_comb begin
      closing_in   = closing_ff;
      last_flip_in = last_flip_ff;
      if (open_flip) begin
         closing_in   = 1'b0;
         last_flip_in = in_ff.now_us;
      end else if (close_flip) begin
         closing_in   = 1'b1;
         last_flip_in = in_ff.now_us;
      end
   end

   // gain select and the two products
   assign kp_sel = closing_in ? valve_kp_ff : motor_kp_ff;
   assign kd_sel = closing_in ? valve_kd_ff : motor_kd_ff;

   always_comb begin
      pr_in.closing = closing_in;
      pr_in.err_neg = err[24];
      pr_in.err_pos = !err[24] && (err != '0);
      pr_in.bias    = closing_in ? valve_bias_ff : motor_bias_ff;
      pr_in.p_err   = $signed({1'b0, kp_sel}) * err;
      pr_in.p_vel   = $signed({1'b0, kd_sel}) * in_ff.velocity;
   end

   // command sum, floor in closing mode, clamp and scale to 0..255
   assign cmd = $signed({19'b0, pr_ff.bias, 16'b0})
              + $signed({{2{pr_ff.p_err[49]}}, pr_ff.p_err})
              - $signed({{3{pr_ff.p_vel[48]}}, pr_ff.p_vel});
   assign cmd_floored = (pr_ff.closing && (cmd < FLOOR_Q32)) ? FLOOR_Q32 : cmd;

   always_comb begin
      if (cmd_floored[51]) begin
         cmd_clamped = '0;
      end else if (cmd_floored > $signed({19'b0, ONE_Q32})) begin
         cmd_clamped = ONE_Q32;
      end else begin
         cmd_clamped = cmd_floored[32:0];
      end
   end

   assign scaled = 40'({cmd_clamped, 8'b0}) - 40'(cmd_clamped);
   assign duty   = scaled[39:32];

   always_comb begin
      out_in.onoff_valve = !pr_ff.closing;
      out_in.closing     = pr_ff.closing;
      if (pr_ff.closing) begin
         out_in.pump_duty  = DUTY_OFF;
         out_in.valve_duty = pr_ff.err_neg ? duty : DUTY_FULL;
      end else begin
         out_in.valve_duty = DUTY_FULL;
         out_in.pump_duty  = pr_ff.err_pos ? duty : DUTY_OFF;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff   <= DEADZONE_WIDTH_RST;
         period_ff     <= SWITCH_PERIOD_US_RST;
         valve_bias_ff <= VALVE_BIAS_RST;
         valve_kp_ff   <= VALVE_GAIN_P_RST;
         valve_kd_ff   <= VALVE_GAIN_D_RST;
         motor_bias_ff <= MOTOR_BIAS_RST;
         motor_kp_ff   <= MOTOR_GAIN_P_RST;
         motor_kd_ff   <= MOTOR_GAIN_D_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEADZONE_WIDTH:   deadzone_ff   <= csr_data[22:0];
            CSR_SWITCH_PERIOD_US: period_ff     <= csr_data;
            CSR_VALVE_BIAS:       valve_bias_ff <= csr_data[16:0];
            CSR_VALVE_GAIN_P:     valve_kp_ff   <= csr_data[23:0];
            CSR_VALVE_GAIN_D:     valve_kd_ff   <= csr_data[23:0];
            CSR_MOTOR_BIAS:       motor_bias_ff <= csr_data[16:0];
            CSR_MOTOR_GAIN_P:     motor_kp_ff   <= csr_data[23:0];
            CSR_MOTOR_GAIN_D:     motor_kd_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // mode state advances as a tick leaves the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         closing_ff   <= 1'b1;
         last_flip_ff <= '0;
      end else if (in_vld_ff && en_pr) begin
         closing_ff   <= closing_in;
         last_flip_ff <= last_flip_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         pr_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (en_in) begin
            in_vld_ff <= req_valid;
         end
         if (en_pr) begin
            pr_vld_ff <= in_vld_ff;
         end
         if (en_out) begin
            out_vld_ff <= pr_vld_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en_in && req_valid) begin
         in_ff <= req_data;
      end
      if (en_pr && in_vld_ff) begin
         pr_ff <= pr_in;
      end
      if (en_out && pr_vld_ff) begin
         out_ff <= out_in;
      end
   end

   // closing mode never runs the pump
   a_closing_pump_off: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.closing |-> out_ff.pump_duty == DUTY_OFF)
      else $error("pump driven in closing mode");

   // opening mode keeps the valve full
   a_opening_valve_full: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ff.closing |-> out_ff.valve_duty == DUTY_FULL)
      else $error("valve not full in opening mode");

   // the valve floor holds through the clamp
   a_valve_floor: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.closing |-> out_ff.valve_duty >= VALVE_FLOOR_DUTY)
      else $error("valve duty below floor");

   // a mode change stamps the flip time of the tick that caused it
   a_flip_stamp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (closing_ff != $past(closing_ff))
      |-> $past(in_vld_ff && en_pr) && (last_flip_ff == $past(in_ff.now_us)))
      else $error("mode changed without a tick or flip time stamp");

endmodule

/* bench/tb_brake_open_close_control_law_core.sv */
module tb_brake_open_close_control_law_core;
   timeunit 1ns;
   timeprecision 1ps;

   import bocl_pkg::*;

   localparam int unsigned RUN_LIMIT    = 500000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int          MAX_REPORTS  = 10;

   // writes that fall outside the register map
   localparam logic [7:0] CSR_UNMAPPED_LOW  = 8'd8;
   localparam logic [7:0] CSR_UNMAPPED_HIGH = 8'hFF;

   // q32 scale points of the command path
   localparam longint FULL_Q32  = 64'sd4294967296;
   localparam longint FLOOR_Q32 = longint'(VALVE_FLOOR) * 65536;

   typedef enum {REG_DEADZONE, REG_PERIOD, REG_BIAS, REG_GAIN} reg_kind_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [7:0]      csr_index;
   logic [31:0]     csr_data;

   brake_open_close_control_law_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // register copies used by the predictor
   logic [22:0] cfg_deadzone   = DEADZONE_WIDTH_RST;
   logic [31:0] cfg_period     = SWITCH_PERIOD_US_RST;
   logic [16:0] cfg_valve_bias = VALVE_BIAS_RST;
   logic [23:0] cfg_valve_kp   = VALVE_GAIN_P_RST;
   logic [23:0] cfg_valve_kd   = VALVE_GAIN_D_RST;
   logic [16:0] cfg_motor_bias = MOTOR_BIAS_RST;
   logic [23:0] cfg_motor_kp   = MOTOR_GAIN_P_RST;
   logic [23:0] cfg_motor_kd   = MOTOR_GAIN_D_RST;

   // latched mode and time of the last flip
   logic        law_closing   = 1'b1;
   logic [31:0] law_last_flip = '0;

   rsp_payload_type pending_duties[$];
   int          mismatch_count  = 0;
   int unsigned cycle_count     = 0;
   int          hold_off_cycles = 0;
   bit          rsp_stall_on    = 1'b1;
   bit          sender_idle_on  = 1'b1;
   logic [31:0] sim_now         = '0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("brake_open_close_control_law_core test failed");
      $finish;
   end

   // bias*2^16 + kp*err - kd*vel, exact
   function automatic longint drive_law(logic [16:0] bias, logic [23:0] kp, logic [23:0] kd,
                                        longint err, longint vel);
      return longint'(bias) * 65536 + longint'(kp) * err - longint'(kd) * vel;
   endfunction

   // clamp to 0..1 in q32 and scale to 0..255
   function automatic logic [7:0] scale_duty(longint cmd);
      longint prod;
      if (cmd < 0) cmd = 0;
      if (cmd > FULL_Q32) cmd = FULL_Q32;
      prod = cmd * 255;
      return 8'(prod >>> 32);
   endfunction

   // mode update and duty computation for one tick
   function automatic rsp_payload_type predict_duties(req_payload_type t);
      longint err;
      longint vel;
      longint dz;
      longint cmd;
      rsp_payload_type r;
      err = longint'($signed(t.setpoint)) - longint'($signed(t.distance));
      vel = longint'($signed(t.velocity));
      dz  = longint'(cfg_deadzone);
      // opening test first, a flip here zeroes the elapsed time
      if (err >= dz && 32'(t.now_us - law_last_flip) > cfg_period) begin
         law_closing   = 1'b0;
         law_last_flip = t.now_us;
      end
      if (err <= -dz && 32'(t.now_us - law_last_flip) > cfg_period) begin
         law_closing   = 1'b1;
         law_last_flip = t.now_us;
      end
      if (law_closing) begin
         r.pump_duty = DUTY_OFF;
         if (err < 0) begin
            cmd = drive_law(cfg_valve_bias, cfg_valve_kp, cfg_valve_kd, err, vel);
            if (cmd < FLOOR_Q32) cmd = FLOOR_Q32;
            r.valve_duty = scale_duty(cmd);
         end else begin
            r.valve_duty = DUTY_FULL;
         end
      end else begin
         r.valve_duty = DUTY_FULL;
         if (err > 0)
            r.pump_duty = scale_duty(drive_law(cfg_motor_bias, cfg_motor_kp, cfg_motor_kd,
                                               err, vel));
         else
            r.pump_duty = DUTY_OFF;
      end
      r.onoff_valve = ~law_closing;
      r.closing     = law_closing;
      return r;
   endfunction

   task automatic apply_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
         CSR_DEADZONE_WIDTH:   cfg_deadzone   = val[22:0];
         CSR_SWITCH_PERIOD_US: cfg_period     = val;
         CSR_VALVE_BIAS:       cfg_valve_bias = val[16:0];
         CSR_VALVE_GAIN_P:     cfg_valve_kp   = val[23:0];
         CSR_VALVE_GAIN_D:     cfg_valve_kd   = val[23:0];
         CSR_MOTOR_BIAS:       cfg_motor_bias = val[16:0];
         CSR_MOTOR_GAIN_P:     cfg_motor_kp   = val[23:0];
         CSR_MOTOR_GAIN_D:     cfg_motor_kd   = val[23:0];
         default: ;
      endcase
   endtask

   // beat monitor: check results, predict ticks, track register writes
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_duties.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("unexpected result beat: valve %0d pump %0d onoff %0b closing %0b",
                           rsp_data.valve_duty, rsp_data.pump_duty, rsp_data.onoff_valve,
                           rsp_data.closing);
               mismatch_count++;
            end else begin
               want = pending_duties.pop_front();
               if (rsp_data.valve_duty !== want.valve_duty ||
                   rsp_data.pump_duty !== want.pump_duty ||
                   rsp_data.onoff_valve !== want.onoff_valve ||
                   rsp_data.closing !== want.closing) begin
                  if (mismatch_count < MAX_REPORTS)
                     $display({"mismatch: valve %0d/%0d pump %0d/%0d onoff %0b/%0b ",
                               "closing %0b/%0b (expected/actual)"},
                              want.valve_duty, rsp_data.valve_duty,
                              want.pump_duty, rsp_data.pump_duty,
                              want.onoff_valve, rsp_data.onoff_valve,
                              want.closing, rsp_data.closing);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            pending_duties.push_back(predict_duties(req_data));
         if (csr_valid && csr_ready)
            apply_reg(csr_index, csr_data);
      end
   end

   // result side: random stalls, quiet stretches, and a counted hold-off
   initial begin
      int n;
      int r;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (!rsp_stall_on) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end else if (r < 95) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 40)) @(posedge clock);
            end
         end
      end
   end

   function automatic int next_gap();
      int r;
      if (!sender_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 12));
      return int'($urandom_range(20, 60));
   endfunction

   function automatic req_payload_type make_tick(logic [31:0] now, int sp, int meas, int vel);
      req_payload_type t;
      t.now_us   = now;
      t.setpoint = 24'(sp);
      t.distance = 24'(meas);
      t.velocity = 24'(vel);
      return t;
   endfunction

   // time-ordered tick with the error mostly near the deadzone edges
   function automatic req_payload_type stream_tick();
      longint span;
      longint dzl;
      longint w;
      longint err;
      longint vel;
      longint lo;
      longint hi;
      longint meas;
      int     r;
      span = longint'(cfg_period) / 2 + 64;
      if (span > 64'sd4294967295) span = 64'sd4294967295;
      sim_now = sim_now + $urandom_range(0, 32'(span));
      dzl = longint'(cfg_deadzone);
      r = $urandom_range(0, 99);
      if (r < 40) begin
         w   = 2 * dzl + 64;
         err = longint'($urandom_range(0, 32'(2 * w))) - w;
      end else if (r < 65) begin
         case ($urandom_range(0, 4))
            0: err = dzl;
            1: err = -dzl;
            2: err = dzl - 1;
            3: err = -dzl + 1;
            default: err = 0;
         endcase
      end else begin
         err = longint'($urandom_range(0, 33554430)) - 16777215;
      end
      if (err > 16777215) err = 16777215;
      if (err < -16777215) err = -16777215;
      lo = -8388608;
      if (-8388608 - err > lo) lo = -8388608 - err;
      hi = 8388607;
      if (8388607 - err < hi) hi = 8388607 - err;
      meas = lo + longint'($urandom_range(0, 32'(hi - lo)));
      r = $urandom_range(0, 99);
      if (r < 60) vel = longint'($urandom_range(0, 524288)) - 262144;
      else if (r < 80) vel = 0;
      else vel = longint'($signed(24'($urandom())));
      return make_tick(sim_now, int'(meas + err), int'(meas), int'(vel));
   endfunction

   // one tick beat, then the idle gap before the next one
   task automatic send_tick(req_payload_type t);
      int gap;
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      gap = next_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // mostly well-formed ticks, the rest unconstrained noise
   task automatic send_mixed(int count);
      req_payload_type t;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 80) begin
            t = stream_tick();
         end else begin
            t.now_us   = $urandom();
            t.setpoint = 24'($urandom());
            t.distance = 24'($urandom());
            t.velocity = 24'($urandom());
         end
         send_tick(t);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_duties.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_settings(logic [31:0] dz, logic [31:0] period,
                                   logic [31:0] vbias, logic [31:0] vkp, logic [31:0] vkd,
                                   logic [31:0] mbias, logic [31:0] mkp, logic [31:0] mkd);
      write_reg(CSR_DEADZONE_WIDTH, dz);
      write_reg(CSR_SWITCH_PERIOD_US, period);
      write_reg(CSR_VALVE_BIAS, vbias);
      write_reg(CSR_VALVE_GAIN_P, vkp);
      write_reg(CSR_VALVE_GAIN_D, vkd);
      write_reg(CSR_MOTOR_BIAS, mbias);
      write_reg(CSR_MOTOR_GAIN_P, mkp);
      write_reg(CSR_MOTOR_GAIN_D, mkd);
   endtask

   // typical values mostly, with edges and stray upper bits now and then
   function automatic logic [31:0] random_reg_value(reg_kind_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         REG_DEADZONE: begin
            if (r < 70) return $urandom_range(0, 20000);
            if (r < 85) return $urandom_range(0, 3);
            return $urandom();
         end
         REG_PERIOD: begin
            if (r < 55) return $urandom_range(0, 300000);
            if (r < 70) return 32'd0;
            if (r < 90) return $urandom_range(0, 1000);
            return $urandom();
         end
         REG_BIAS: begin
            if (r < 80) return $urandom_range(0, 65536);
            if (r < 90) return 32'd65536;
            return $urandom();
         end
         default: begin
            if (r < 70) return $urandom_range(0, 200000);
            if (r < 85) return $urandom_range(0, 24'hFFFFFF);
            return $urandom();
         end
      endcase
   endfunction

   task automatic program_random();
      program_settings(random_reg_value(REG_DEADZONE), random_reg_value(REG_PERIOD),
                       random_reg_value(REG_BIAS), random_reg_value(REG_GAIN),
                       random_reg_value(REG_GAIN), random_reg_value(REG_BIAS),
                       random_reg_value(REG_GAIN), random_reg_value(REG_GAIN));
   endtask

   // reset settings: field extremes, deadzone and period edges, time wrap
   task automatic test_default_law();
      send_tick(make_tick(32'd0, 0, 0, 0));
      send_tick(make_tick(32'd100, 0, 1, 0));
      send_tick(make_tick(32'd200, -8388608, 8388607, 8388607));
      send_tick(make_tick(32'd300, 0, 100, -8388608));
      send_tick(make_tick(32'd400, 0, 6554, 0));
      // elapsed equal to the period does not flip
      send_tick(make_tick(32'd250000, 6554, 0, 0));
      send_tick(make_tick(32'd250001, 6554, 0, 0));
      send_tick(make_tick(32'd250002, 8388607, -8388608, -8388608));
      send_tick(make_tick(32'd250003, 0, 0, 0));
      send_tick(make_tick(32'd250004, 0, 100, 50));
      send_tick(make_tick(32'd250005, 100, 0, 8388607));
      send_tick(make_tick(32'd500001, -6554, 0, 0));
      send_tick(make_tick(32'd500002, -6554, 0, 0));
      send_tick(make_tick(32'd500003, -6553, 0, 0));
      // elapsed time across the 32-bit wrap
      send_tick(make_tick(32'hFFFF_FF00, 6554, 0, 0));
      send_tick(make_tick(32'h0003_D000, -7000, 0, 100));
      send_tick(make_tick(32'h0003_D001, 7000, 0, 0));
      send_tick(make_tick(32'hFFFF_FFFF, -1, -1, -1));
      send_tick(make_tick(32'h8000_0000, 8388607, 8388607, 0));
      wait_drained();
   endtask

   // zero deadzone and period: zero error opens, closing test sees no elapsed time
   task automatic test_zero_deadzone();
      program_settings(0, 0, 32'(VALVE_BIAS_RST), 32'(VALVE_GAIN_P_RST),
                       32'(VALVE_GAIN_D_RST), 32'(MOTOR_BIAS_RST), 32'(MOTOR_GAIN_P_RST),
                       32'(MOTOR_GAIN_D_RST));
      send_tick(make_tick(32'd1000, 0, 0, 0));
      send_tick(make_tick(32'd1000, 0, 1, 0));
      send_tick(make_tick(32'd1001, 0, 1, 0));
      send_tick(make_tick(32'd1001, 0, 0, 0));
      send_tick(make_tick(32'd1002, 0, 0, 0));
      send_tick(make_tick(32'd1002, 5, 0, 0));
      send_tick(make_tick(32'd1003, 0, 5, -3));
      wait_drained();
   endtask

   task automatic test_register_extremes();
      program_settings(0, 0, 0, 0, 0, 0, 0, 0);
      send_mixed(20);
      wait_drained();
      program_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_mixed(20);
      wait_drained();
      // top of the stated ranges with a zero period so flips happen
      program_settings(8388607, 0, 65536, 32'h00FF_FFFF, 32'h00FF_FFFF, 65536,
                       32'h00FF_FFFF, 32'h00FF_FFFF);
      send_mixed(20);
      wait_drained();
   endtask

   // writes past the register map change nothing
   task automatic test_unmapped_index();
      program_random();
      write_reg(CSR_UNMAPPED_LOW, $urandom());
      write_reg(CSR_UNMAPPED_HIGH, $urandom());
      send_mixed(12);
      wait_drained();
   endtask

   // long receiver hold-off while ticks keep coming, so the input stalls
   task automatic test_output_stall();
      program_settings(32'(DEADZONE_WIDTH_RST), 1000, 32'(VALVE_BIAS_RST),
                       32'(VALVE_GAIN_P_RST), 32'(VALVE_GAIN_D_RST), 32'(MOTOR_BIAS_RST),
                       32'(MOTOR_GAIN_P_RST), 32'(MOTOR_GAIN_D_RST));
      rsp_stall_on    = 1'b0;
      sender_idle_on  = 1'b0;
      hold_off_cycles = 300;
      for (int i = 0; i < 40; i++)
         send_tick(stream_tick());
      wait_drained();
      rsp_stall_on   = 1'b1;
      sender_idle_on = 1'b1;
   endtask

   // several random settings; one of them runs with no idling at all
   task automatic test_random_settings();
      for (int s = 0; s < 10; s++) begin
         program_random();
         rsp_stall_on   = (s != 4);
         sender_idle_on = (s != 4);
         send_mixed(45);
         wait_drained();
      end
      rsp_stall_on   = 1'b1;
      sender_idle_on = 1'b1;
   endtask

   // sequence
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_default_law();
      test_zero_deadzone();
      test_register_extremes();
      test_unmapped_index();
      test_output_stall();
      test_random_settings();
      wait_drained();
      if (mismatch_count == 0 && pending_duties.size() == 0) begin
         $display("brake_open_close_control_law_core test passed");
      end else begin
         $display("brake_open_close_control_law_core test failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/bocl_pkg.sv
hw/rtl/brake_open_close_control_law_core.sv
bench/tb_brake_open_close_control_law_core.sv
